FILE: sv/fcfs_multi_cpu_dispatcher_top_assert.svh
// Assertion macros used by the dispatcher control module
`ifndef FCFS_MULTI_CPU_DISPATCHER_TOP_ASSERT_SVH
`define FCFS_MULTI_CPU_DISPATCHER_TOP_ASSERT_SVH

// Same-cycle implication
`define FCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/fcd_pkg.sv
package fcd_pkg;

    localparam int NUM_CPUS    = 5;
    localparam int QUEUE_DEPTH = 1024;

    localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CNT_W   = $clog2(NUM_CPUS + 1);
    localparam int QW      = $clog2(QUEUE_DEPTH);
    localparam int QCW     = QW + 1;
    localparam int COUNT_W = 10;
    localparam int IDX_W   = 3;
    localparam int TASK_W  = 10;
    localparam int DUR_W   = 8;
    localparam int TICK_W  = 32;
    localparam int ACT_W   = 3;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(5);

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [TASK_W-1:0] task_id;
        logic [DUR_W-1:0]  duration;
    } fcd_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TASK_W-1:0]  done_task;
        logic [IDX_W-1:0]   cpu_index;
        logic [TICK_W-1:0]  finish_tick;
        logic               dropped;
        logic [COUNT_W-1:0] queue_count;
        logic               last;
    } fcd_out_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [DUR_W-1:0]  duration;
    } fcd_qent_t;

    localparam int QENT_W = $bits(fcd_qent_t);

    typedef struct packed {
        logic              busy;
        logic [TASK_W-1:0] task_id;
        logic [DUR_W-1:0]  remaining;
        logic [TICK_W-1:0] idle_ticks;
    } fcd_cpu_t;

    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [CPU_W-1:0] addr;
        fcd_cpu_t         wdata;
    } fcd_cpu_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSP_RD,
        ST_DSP_WR,
        ST_DEC_RD,
        ST_DEC_WR,
        ST_TICK_OUT
    } fcd_state_t;

    function automatic logic [QW-1:0] q_next(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
    endfunction

    function automatic logic [COUNT_W-1:0] q_count(input logic [QW-1:0] head,
                                                   input logic [QW-1:0] tail);
        logic [QCW-1:0] diff;
        if (tail >= head)
        begin
            diff = {1'b0, tail} - {1'b0, head};
        end
        else
        begin
            diff = {1'b0, tail} + QCW'(QUEUE_DEPTH) - {1'b0, head};
        end
        return COUNT_W'(diff);
    endfunction

endpackage

FILE: sv/fcd_ram.sv
module fcd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fcd_cpu_tbl.sv
module fcd_cpu_tbl
    import fcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fcd_cpu_req_t req,
    output fcd_cpu_t     rdata
);

    fcd_cpu_t            mem [NUM_CPUS];
    fcd_cpu_t            rdata_reg;
    logic [NUM_CPUS-1:0] valid_reg;
    logic                rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    // unwritten entries read as the cleared state
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: sv/fcd_ctrl.sv
module fcd_ctrl
    import fcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fcd_in_t           item,
    input  logic [ACT_W-1:0]  active_cpus,
    input  logic              emit_ready,
    output logic              emit_valid,
    output fcd_out_t          emit,
    output logic              q_we,
    output logic [QW-1:0]     q_waddr,
    output logic [QENT_W-1:0] q_wdata,
    output logic              q_re,
    output logic [QW-1:0]     q_raddr,
    input  logic [QENT_W-1:0] q_rdata,
    output fcd_cpu_req_t      cpu_req,
    input  fcd_cpu_t          cpu_rdata
);

    `include "fcfs_multi_cpu_dispatcher_top_assert.svh"

    fcd_state_t        state_reg, state_next;
    logic [QW-1:0]     head_reg, head_next;
    logic [QW-1:0]     tail_reg, tail_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [CPU_W-1:0]  idx_reg, idx_next;

    logic [CNT_W-1:0]  n_cpus;
    logic              q_empty;
    logic              q_full;
    logic              accept;
    logic              dsp_last;
    logic              dec_last;
    fcd_qent_t         qent;
    logic [DUR_W-1:0]  dur_fix;
    logic [DUR_W-1:0]  rem_dec;

    always_comb
    begin
        if (active_cpus == '0)
        begin
            n_cpus = CNT_W'(1);
        end
        else if (int'(active_cpus) > NUM_CPUS)
        begin
            n_cpus = CNT_W'(NUM_CPUS);
        end
        else
        begin
            n_cpus = CNT_W'(active_cpus);
        end
    end

    assign q_empty    = (head_reg == tail_reg);
    assign q_full     = (q_next(tail_reg) == head_reg);
    assign item_ready = (state_reg == ST_IDLE) && emit_ready;
    assign accept     = item_valid && item_ready;
    assign dsp_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_cpus);
    assign dec_last   = (idx_reg == CPU_W'(NUM_CPUS - 1));
    assign qent       = fcd_qent_t'(q_rdata);
    assign dur_fix    = (item.duration == '0) ? DUR_W'(1) : item.duration;
    assign rem_dec    = (cpu_rdata.remaining != '0) ? cpu_rdata.remaining - DUR_W'(1) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            tick_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            tick_reg  <= tick_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        tick_next  = tick_reg;
        idx_next   = idx_reg;

        emit_valid = 1'b0;
        emit       = '0;

        q_we    = 1'b0;
        q_waddr = tail_reg;
        q_wdata = QENT_W'({item.task_id, dur_fix});
        q_re    = 1'b0;
        q_raddr = head_reg;

        cpu_req       = '0;
        cpu_req.addr  = idx_reg;
        cpu_req.wdata = cpu_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_SUBMIT)
                    begin
                        if (!q_full)
                        begin
                            q_we      = 1'b1;
                            tail_next = q_next(tail_reg);
                        end
                        emit_valid       = 1'b1;
                        emit.kind        = KIND_ACK;
                        emit.done_task   = item.task_id;
                        emit.dropped     = q_full;
                        emit.queue_count = q_count(head_reg, tail_next);
                        emit.last        = 1'b1;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_DSP_RD;
                    end
                end
            end

            ST_DSP_RD:
            begin
                cpu_req.rd = 1'b1;
                q_re       = 1'b1;
                state_next = ST_DSP_WR;
            end

            ST_DSP_WR:
            begin
                if (!cpu_rdata.busy)
                begin
                    cpu_req.wr = 1'b1;
                    if (!q_empty)
                    begin
                        cpu_req.wdata.busy      = 1'b1;
                        cpu_req.wdata.task_id   = qent.task_id;
                        cpu_req.wdata.remaining = qent.duration;
                        head_next               = q_next(head_reg);
                    end
                    else
                    begin
                        cpu_req.wdata.idle_ticks = cpu_rdata.idle_ticks + TICK_W'(1);
                    end
                end
                if (dsp_last)
                begin
                    idx_next   = '0;
                    state_next = ST_DEC_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CPU_W'(1);
                    state_next = ST_DSP_RD;
                end
            end

            ST_DEC_RD:
            begin
                cpu_req.rd = 1'b1;
                state_next = ST_DEC_WR;
            end

            ST_DEC_WR:
            begin
                priority if (cpu_rdata.busy && rem_dec == '0 && !emit_ready)
                begin
                    // hold until the output slot frees
                    state_next = ST_DEC_WR;
                end
                else
                begin
                    if (cpu_rdata.busy)
                    begin
                        cpu_req.wr              = 1'b1;
                        cpu_req.wdata.remaining = rem_dec;
                        if (rem_dec == '0)
                        begin
                            cpu_req.wdata.busy    = 1'b0;
                            cpu_req.wdata.task_id = '0;
                            emit_valid            = 1'b1;
                            emit.kind             = KIND_DONE;
                            emit.done_task        = cpu_rdata.task_id;
                            emit.cpu_index        = IDX_W'(idx_reg);
                            emit.finish_tick      = tick_reg;
                            emit.queue_count      = q_count(head_reg, tail_reg);
                        end
                    end
                    if (dec_last)
                    begin
                        state_next = ST_TICK_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CPU_W'(1);
                        state_next = ST_DEC_RD;
                    end
                end
            end

            ST_TICK_OUT:
            begin
                if (emit_ready)
                begin
                    emit_valid       = 1'b1;
                    emit.kind        = KIND_TICK;
                    emit.finish_tick = tick_reg;
                    emit.queue_count = q_count(head_reg, tail_reg);
                    emit.last        = 1'b1;
                    tick_next        = tick_reg + TICK_W'(1);
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FCD_ASSERT_NOW(a_emit_slot_free, clk, rst_n, emit_valid, emit_ready, "beat into full slot")
    `FCD_ASSERT_NEXT(a_tick_starts_pass, clk, rst_n, accept && item.cmd == CMD_TICK,
                     state_reg == ST_DSP_RD, "tick did not start dispatch")
    `FCD_ASSERT_NEXT(a_tick_advance, clk, rst_n, emit_valid && emit.kind == KIND_TICK,
                     tick_reg == $past(tick_reg) + TICK_W'(1), "tick count did not advance")
    `FCD_ASSERT_NOW(a_no_empty_pop, clk, rst_n, head_next != head_reg,
                    state_reg == ST_DSP_WR && !q_empty, "pop from empty queue")

endmodule

FILE: sv/fcfs_multi_cpu_dispatcher_top.sv
// First-come-first-served dispatcher for NUM_CPUS processors. A submit beat
// stores a task in a ready queue of QUEUE_DEPTH entries (it holds at most
// QUEUE_DEPTH-1 tasks; a submit to a full queue is acknowledged with dropped
// set). A tick beat visits the processor table, a one-port memory with a
// registered read, read-then-write once per active processor (the clamped
// active_cpus) for dispatch and once per processor for the countdown, then
// the tick done beat goes out. The sequence stalls while a result beat
// waits in the output register with result_ready low and another beat is
// due. The memories need no clearing pass after reset.
module fcfs_multi_cpu_dispatcher_top
    import fcd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  fcd_in_t          item,
    output logic             result_valid,
    input  logic             result_ready,
    output fcd_out_t         result,
    input  logic             cfg_we,
    input  logic [ACT_W-1:0] cfg_wdata
);

    logic [ACT_W-1:0]  active_cpus_reg;
    fcd_out_t          result_reg;
    logic              result_valid_reg;

    logic              emit_ready;
    logic              emit_valid;
    fcd_out_t          emit;
    logic              q_we;
    logic [QW-1:0]     q_waddr;
    logic [QENT_W-1:0] q_wdata;
    logic              q_re;
    logic [QW-1:0]     q_raddr;
    logic [QENT_W-1:0] q_rdata;
    fcd_cpu_req_t      cpu_req;
    fcd_cpu_t          cpu_rdata;

    assign emit_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cpus_reg  <= ACTIVE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_cpus_reg <= cfg_wdata;
            end
            if (emit_valid)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            result_reg <= emit;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    fcd_ram #(
        .WIDTH (QENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    fcd_cpu_tbl u_cpu_tbl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cpu_req),
        .rdata (cpu_rdata)
    );

    fcd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .active_cpus (active_cpus_reg),
        .emit_ready  (emit_ready),
        .emit_valid  (emit_valid),
        .emit        (emit),
        .q_we        (q_we),
        .q_waddr     (q_waddr),
        .q_wdata     (q_wdata),
        .q_re        (q_re),
        .q_raddr     (q_raddr),
        .q_rdata     (q_rdata),
        .cpu_req     (cpu_req),
        .cpu_rdata   (cpu_rdata)
    );

endmodule
